// ===== rtl/core/dsp_pkg.sv =====
// shared types and constants of the dictionary sequence parser
`default_nettype none

package dsp_pkg;

    // result kinds
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_ENTRY    = 3'd1;
    localparam logic [2:0] KIND_CLOSED   = 3'd2;
    localparam logic [2:0] KIND_FALLBACK = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_ENTRY_LONG   = 3'd2;
    localparam logic [2:0] ERR_ENTRY_BOUNDS = 3'd3;
    localparam logic [2:0] ERR_OVER_BUDGET  = 3'd4;
    localparam logic [2:0] ERR_TRUNC_COUNT  = 3'd5;
    localparam logic [2:0] ERR_ROWS_EXCEED  = 3'd6;
    localparam logic [2:0] ERR_TOO_MANY     = 3'd7;

    // stream markers and limits
    localparam logic [7:0] MARKER_NEXT   = 8'hFE;
    localparam logic [7:0] MARKER_LAST   = 8'hFF;
    localparam logic [7:0] MAX_ENTRY_LEN = 8'd63;
    localparam logic [1:0] COUNT_LAST    = 2'd3;   // position of the 4th count byte

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  dict_number;
        logic [5:0]  entry_number;
        logic [7:0]  byte_out;
        logic [5:0]  entry_count;
        logic [31:0] matched_rows;
        logic [39:0] matched_total;
        logic        sequence_done;
        logic [2:0]  error_code;
        logic        stream_end;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/dsp_parse.sv =====
// parser state and per-byte result logic
`default_nettype none

module dsp_parse #(
    parameter int MAX_DICTS   = 256,
    parameter int DICT_BUDGET = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_acc,
    input  wire  [7:0]        i_data,
    input  wire               i_last,
    input  wire  [31:0]       i_rows,
    output dsp_pkg::t_result  o_res
);

    localparam logic [1:0] PH_LEN      = 2'd0;
    localparam logic [1:0] PH_ENTRY    = 2'd1;
    localparam logic [1:0] PH_COUNT    = 2'd2;
    localparam logic [1:0] PH_FALLBACK = 2'd3;

    localparam logic [8:0] MaxDictsW = 9'(MAX_DICTS);
    localparam logic [6:0] BudgetW   = 7'(DICT_BUDGET);

    logic [1:0]  r_phase,  n_phase;
    logic [5:0]  r_left,   n_left;
    logic [6:0]  r_budget, n_budget;
    logic [7:0]  r_dict,   n_dict;
    logic [5:0]  r_entry,  n_entry;
    logic [1:0]  r_pos,    n_pos;
    logic [31:0] r_accum,  n_accum;
    logic [39:0] r_sum,    n_sum;
    logic        r_final,  n_final;
    logic        r_err,    n_err;

    logic        err;
    logic [2:0]  err_code;
    logic [6:0]  used;
    logic [31:0] accum;
    logic [39:0] sum;
    logic [5:0]  left_dec;
    dsp_pkg::t_result res;

    // next state and result for the byte at the input
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_budget = r_budget;
        n_dict   = r_dict;
        n_entry  = r_entry;
        n_pos    = r_pos;
        n_accum  = r_accum;
        n_sum    = r_sum;
        n_final  = r_final;
        n_err    = r_err;
        err      = 1'b0;
        err_code = dsp_pkg::ERR_NONE;
        res      = '0;
        res.dict_number = r_dict;
        used     = r_budget + 7'(i_data) + 7'd1;
        accum    = r_accum | ({24'd0, i_data} << {r_pos, 3'b000});
        sum      = r_sum + {8'd0, accum};
        left_dec = r_left - 6'd1;

        if (r_err) begin
            // discard until the end of the stream
            err = 1'b1;
        end else begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_data >= dsp_pkg::MARKER_NEXT) begin
                        n_final = (i_data == dsp_pkg::MARKER_LAST);
                        n_phase = PH_COUNT;
                        n_pos   = 2'd0;
                        n_accum = 32'd0;
                        res.kind     = dsp_pkg::KIND_HEADER;
                        res.byte_out = i_data;
                        if (i_last) begin
                            err      = 1'b1;
                            err_code = dsp_pkg::ERR_TRUNC_COUNT;
                        end
                    end else if (i_data > dsp_pkg::MAX_ENTRY_LEN) begin
                        err      = 1'b1;
                        err_code = dsp_pkg::ERR_ENTRY_LONG;
                    end else if (i_last && i_data != 8'd0) begin
                        err      = 1'b1;
                        err_code = dsp_pkg::ERR_ENTRY_BOUNDS;
                    end else if (used >= BudgetW) begin
                        err      = 1'b1;
                        err_code = dsp_pkg::ERR_OVER_BUDGET;
                    end else begin
                        n_budget = used;
                        res.kind         = dsp_pkg::KIND_HEADER;
                        res.entry_number = r_entry;
                        res.byte_out     = i_data;
                        n_entry = r_entry + 6'd1;
                        if (i_data != 8'd0) begin
                            n_left  = i_data[5:0];
                            n_phase = PH_ENTRY;
                        end
                        if (i_last) begin
                            err      = 1'b1;
                            err_code = dsp_pkg::ERR_UNTERMINATED;
                        end
                    end
                end
                PH_ENTRY: begin
                    res.kind         = dsp_pkg::KIND_ENTRY;
                    res.entry_number = r_entry - 6'd1;
                    res.byte_out     = i_data;
                    n_left = left_dec;
                    if (left_dec == 6'd0) begin
                        n_phase = PH_LEN;
                    end
                    if (i_last) begin
                        err      = 1'b1;
                        err_code = (left_dec != 6'd0) ? dsp_pkg::ERR_ENTRY_BOUNDS
                                                      : dsp_pkg::ERR_UNTERMINATED;
                    end
                end
                PH_COUNT: begin
                    n_accum = accum;
                    if (r_pos != dsp_pkg::COUNT_LAST) begin
                        n_pos = r_pos + 2'd1;
                        res.kind     = dsp_pkg::KIND_HEADER;
                        res.byte_out = i_data;
                        if (i_last) begin
                            err      = 1'b1;
                            err_code = dsp_pkg::ERR_TRUNC_COUNT;
                        end
                    end else begin
                        n_sum = sum;
                        n_pos = 2'd0;
                        res.kind          = dsp_pkg::KIND_CLOSED;
                        res.entry_count   = r_entry;
                        res.matched_rows  = accum;
                        res.matched_total = sum;
                        res.sequence_done = r_final;
                        if (r_final) begin
                            if (sum > {8'd0, i_rows}) begin
                                err      = 1'b1;
                                err_code = dsp_pkg::ERR_ROWS_EXCEED;
                            end else begin
                                n_phase = PH_FALLBACK;
                            end
                        end else if ({1'b0, r_dict} + 9'd1 >= MaxDictsW) begin
                            err      = 1'b1;
                            err_code = dsp_pkg::ERR_TOO_MANY;
                        end else begin
                            n_dict   = r_dict + 8'd1;
                            n_entry  = 6'd0;
                            n_budget = 7'd0;
                            n_phase  = PH_LEN;
                            if (i_last) begin
                                err      = 1'b1;
                                err_code = dsp_pkg::ERR_UNTERMINATED;
                            end
                        end
                    end
                end
                PH_FALLBACK: begin
                    res.kind        = dsp_pkg::KIND_FALLBACK;
                    res.dict_number = 8'd0;
                    res.byte_out    = i_data;
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end

        // an error replaces the normal result
        if (err) begin
            res             = '0;
            res.kind        = dsp_pkg::KIND_ERROR;
            res.dict_number = r_dict;
            res.error_code  = err_code;
            n_err           = 1'b1;
        end
        res.stream_end = i_last;

        // end of stream returns the parser to its start
        if (i_last) begin
            n_phase  = PH_LEN;
            n_left   = 6'd0;
            n_budget = 7'd0;
            n_dict   = 8'd0;
            n_entry  = 6'd0;
            n_pos    = 2'd0;
            n_accum  = 32'd0;
            n_sum    = 40'd0;
            n_final  = 1'b0;
            n_err    = 1'b0;
        end
    end

    assign o_res = res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN;
            r_left   <= 6'd0;
            r_budget <= 7'd0;
            r_dict   <= 8'd0;
            r_entry  <= 6'd0;
            r_pos    <= 2'd0;
            r_accum  <= 32'd0;
            r_sum    <= 40'd0;
            r_final  <= 1'b0;
            r_err    <= 1'b0;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_budget <= n_budget;
            r_dict   <= n_dict;
            r_entry  <= n_entry;
            r_pos    <= n_pos;
            r_accum  <= n_accum;
            r_sum    <= n_sum;
            r_final  <= n_final;
            r_err    <= n_err;
        end
    end

    // a latched error discards every byte up to the stream end
    a_err_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_err) |-> (o_res.kind == dsp_pkg::KIND_ERROR &&
                              o_res.error_code == dsp_pkg::ERR_NONE))
        else $error("byte after error not discarded");

    // inside an entry there is always a byte still owed
    a_entry_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ENTRY && !r_err) |-> (r_left != 6'd0))
        else $error("entry phase with no bytes left");

    // the used budget stays below the dictionary limit
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_budget < BudgetW)
        else $error("dictionary budget overrun");

endmodule

`default_nettype wire

// ===== rtl/core/dictionary_sequence_parser_unit.sv =====
// top level of the dictionary sequence parser: config, handshake and output buffering
`default_nettype none

// Parses a dictionary-encoded string column one byte per cycle: each request on the
// slave side yields exactly one result on the master side, built in a single pass from
// the parser state and registered into an output stage backed by one skid entry. A new
// byte is taken every cycle as long as the skid entry is free, so with the master side
// ready the sustained rate is one byte per clock. The user must set the non-null row
// count via i_cfg_we/i_cfg_wdata with the stream idle; the block does not enforce it.
module dictionary_sequence_parser_unit #(
    parameter int MAX_DICTS   = 256,
    parameter int DICT_BUDGET = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // data_byte
    input  wire          s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // dict_number, entry_number, byte_out, entry_count, matched_rows, matched_total,
    // sequence_done, error_code
    output logic [103:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // stream_end
);

    logic [31:0]      r_rows;
    logic             r_out_valid;
    logic             r_skid_valid;
    dsp_pkg::t_result r_out;
    dsp_pkg::t_result r_skid;
    dsp_pkg::t_result res;
    logic             accept;
    logic             out_free;

    // non-null row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 32'd0;
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    dsp_parse #(
        .MAX_DICTS   (MAX_DICTS),
        .DICT_BUDGET (DICT_BUDGET)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (accept),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_rows  (r_rows),
        .o_res   (res)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (accept) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    // master side
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.stream_end;
    assign m_axis_tdata  = {r_out.error_code, r_out.sequence_done, r_out.matched_total,
                            r_out.matched_rows, r_out.entry_count, r_out.byte_out,
                            r_out.entry_number, r_out.dict_number};

    // the skid entry is only used behind a full output register
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a request taken while the output stalls lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("request lost while output stalled");

    // a drained skid entry frees up in the next cycle
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> !r_skid_valid)
        else $error("skid entry not drained");

endmodule

`default_nettype wire

// ===== dv/dict_parse_checker.sv =====
// checker for the dictionary sequence parser: byte-level prediction and result compare
module dict_parse_checker #(
    parameter int MAX_DICTS   = 256,
    parameter int DICT_BUDGET = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata,
    input  wire          i_req_valid,
    input  wire          i_req_ready,
    input  wire  [7:0]   i_req_byte,
    input  wire          i_req_last,
    input  wire          i_res_valid,
    input  wire          i_res_ready,
    input  wire  [103:0] i_res_data,   // dict_number, entry_number, byte_out, entry_count,
                                       // matched_rows, matched_total, sequence_done, error_code
    input  wire  [2:0]   i_res_kind,
    input  wire          i_res_end,
    output int           o_fail_count,
    output int           o_parses_pending,
    output int           o_results_seen,
    output int           o_closes_seen,
    output int           o_errors_seen
);

    localparam int REPORT_CAP = 60;   // keep the log readable on a badly broken block

    typedef enum logic [1:0] {AT_LENGTH, IN_ENTRY, IN_COUNT, IN_FALLBACK} t_parse_phase;

    // parser state as the block should hold it
    t_parse_phase phase;
    logic [5:0]   entry_left;
    logic [6:0]   budget_used;
    logic [7:0]   dict_idx;
    logic [5:0]   entry_idx;
    logic [1:0]   count_pos;
    logic [31:0]  count_value;
    logic [39:0]  matched_sum;
    logic         final_seen;
    logic         in_error;
    logic [31:0]  rows_limit;

    dsp_pkg::t_result parse_results[$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void clear_parser();
        phase       = AT_LENGTH;
        entry_left  = '0;
        budget_used = '0;
        dict_idx    = '0;
        entry_idx   = '0;
        count_pos   = '0;
        count_value = '0;
        matched_sum = '0;
        final_seen  = 1'b0;
        in_error    = 1'b0;
    endfunction

    // an error result replaces whatever the byte would have given
    function automatic dsp_pkg::t_result error_result(input logic [7:0] dict_no,
                                                      input logic [2:0] code);
        dsp_pkg::t_result r;
        r             = '0;
        r.kind        = dsp_pkg::KIND_ERROR;
        r.dict_number = dict_no;
        r.error_code  = code;
        in_error      = 1'b1;
        return r;
    endfunction

    // one stream byte in, one parse result out
    function automatic dsp_pkg::t_result parse_byte(input logic [7:0] b, input logic last);
        dsp_pkg::t_result r;
        logic [7:0]       dn;
        int               used;
        dn            = dict_idx;
        r             = '0;
        r.kind        = dsp_pkg::KIND_HEADER;
        r.dict_number = dn;
        if (in_error) begin
            r = error_result(dn, dsp_pkg::ERR_NONE);
        end else begin
            case (phase)
                AT_LENGTH: begin
                    if (b >= dsp_pkg::MARKER_NEXT) begin
                        final_seen  = (b == dsp_pkg::MARKER_LAST);
                        phase       = IN_COUNT;
                        count_pos   = '0;
                        count_value = '0;
                        r.byte_out  = b;
                        if (last) r = error_result(dn, dsp_pkg::ERR_TRUNC_COUNT);
                    end else if (b > dsp_pkg::MAX_ENTRY_LEN) begin
                        r = error_result(dn, dsp_pkg::ERR_ENTRY_LONG);
                    end else if (last && b != 8'd0) begin
                        r = error_result(dn, dsp_pkg::ERR_ENTRY_BOUNDS);
                    end else begin
                        used = int'(budget_used) + 1 + int'(b);
                        if (used >= DICT_BUDGET) begin
                            r = error_result(dn, dsp_pkg::ERR_OVER_BUDGET);
                        end else begin
                            budget_used    = used[6:0];
                            r.entry_number = entry_idx;
                            r.byte_out     = b;
                            entry_idx      = entry_idx + 6'd1;
                            if (b != 8'd0) begin
                                entry_left = b[5:0];
                                phase      = IN_ENTRY;
                            end
                            if (last) r = error_result(dn, dsp_pkg::ERR_UNTERMINATED);
                        end
                    end
                end
                IN_ENTRY: begin
                    r.kind         = dsp_pkg::KIND_ENTRY;
                    r.entry_number = entry_idx - 6'd1;
                    r.byte_out     = b;
                    entry_left     = entry_left - 6'd1;
                    if (entry_left == 6'd0) phase = AT_LENGTH;
                    if (last) begin
                        r = error_result(dn, (entry_left != 6'd0) ? dsp_pkg::ERR_ENTRY_BOUNDS
                                                                  : dsp_pkg::ERR_UNTERMINATED);
                    end
                end
                IN_COUNT: begin
                    count_value = count_value | (32'(b) << (8 * count_pos));
                    if (count_pos != dsp_pkg::COUNT_LAST) begin
                        count_pos  = count_pos + 2'd1;
                        r.byte_out = b;
                        if (last) r = error_result(dn, dsp_pkg::ERR_TRUNC_COUNT);
                    end else begin
                        // fourth count byte closes the dictionary
                        matched_sum     = matched_sum + 40'(count_value);
                        r.kind          = dsp_pkg::KIND_CLOSED;
                        r.entry_count   = entry_idx;
                        r.matched_rows  = count_value;
                        r.matched_total = matched_sum;
                        r.sequence_done = final_seen;
                        count_pos       = '0;
                        if (final_seen) begin
                            if (matched_sum > {8'd0, rows_limit})
                                r = error_result(dn, dsp_pkg::ERR_ROWS_EXCEED);
                            else
                                phase = IN_FALLBACK;
                        end else if (int'(dict_idx) + 1 >= MAX_DICTS) begin
                            r = error_result(dn, dsp_pkg::ERR_TOO_MANY);
                        end else begin
                            dict_idx    = dict_idx + 8'd1;
                            entry_idx   = '0;
                            budget_used = '0;
                            phase       = AT_LENGTH;
                            if (last) r = error_result(dn, dsp_pkg::ERR_UNTERMINATED);
                        end
                    end
                end
                default: begin
                    r.kind        = dsp_pkg::KIND_FALLBACK;
                    r.dict_number = '0;
                    r.byte_out    = b;
                end
            endcase
        end
        r.stream_end = last;
        if (last) clear_parser();
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [39:0] want,
                                          input logic [39:0] seen);
        if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    // predict on every accepted request, compare on every accepted result
    always @(posedge i_clk) begin
        dsp_pkg::t_result want;
        dsp_pkg::t_result seen;
        if (!i_rst_n) begin
            clear_parser();
            rows_limit = '0;
            parse_results.delete();
        end else begin
            if (i_cfg_we) rows_limit = i_cfg_wdata;
            if (i_req_valid && i_req_ready)
                parse_results = {parse_results, parse_byte(i_req_byte, i_req_last)};
            if (i_res_valid && i_res_ready) begin
                seen.kind          = i_res_kind;
                seen.dict_number   = i_res_data[7:0];
                seen.entry_number  = i_res_data[13:8];
                seen.byte_out      = i_res_data[21:14];
                seen.entry_count   = i_res_data[27:22];
                seen.matched_rows  = i_res_data[59:28];
                seen.matched_total = i_res_data[99:60];
                seen.sequence_done = i_res_data[100];
                seen.error_code    = i_res_data[103:101];
                seen.stream_end    = i_res_end;
                o_results_seen++;
                if (seen.kind == dsp_pkg::KIND_CLOSED) o_closes_seen++;
                if (seen.kind == dsp_pkg::KIND_ERROR) o_errors_seen++;
                if (parse_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result mismatch, expected none, got kind %0d byte %0h",
                                 $time, seen.kind, seen.byte_out);
                end else begin
                    want = parse_results.pop_front();
                    compare_field("kind", 40'(want.kind), 40'(seen.kind));
                    compare_field("dict_number", 40'(want.dict_number),
                                  40'(seen.dict_number));
                    compare_field("entry_number", 40'(want.entry_number),
                                  40'(seen.entry_number));
                    compare_field("byte_out", 40'(want.byte_out), 40'(seen.byte_out));
                    compare_field("entry_count", 40'(want.entry_count),
                                  40'(seen.entry_count));
                    compare_field("matched_rows", 40'(want.matched_rows),
                                  40'(seen.matched_rows));
                    compare_field("matched_total", want.matched_total, seen.matched_total);
                    compare_field("sequence_done", 40'(want.sequence_done),
                                  40'(seen.sequence_done));
                    compare_field("error_code", 40'(want.error_code), 40'(seen.error_code));
                    compare_field("stream_end", 40'(want.stream_end), 40'(seen.stream_end));
                end
            end
        end
        o_parses_pending <= parse_results.size();
    end

endmodule

// ===== dv/tb_dictionary_sequence_parser_unit.sv =====
// testbench top for the dictionary sequence parser unit: stimulus, idling and verdict
module tb_dictionary_sequence_parser_unit;

    localparam int MAX_DICTS   = 256;
    localparam int DICT_BUDGET = 64;
    localparam int TOTAL_ITEMS = 1450;
    localparam int CALM_ITEMS  = 60;
    localparam int STALL_LIMIT = 1000;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [31:0]  i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;   // data_byte
    logic         s_axis_tlast  = 1'b0; // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;         // dict_number, entry_number, byte_out, entry_count,
                                        // matched_rows, matched_total, sequence_done, error_code
    logic [2:0]   m_axis_tuser;         // kind
    logic         m_axis_tlast;         // stream_end

    int fail_count;
    int parses_pending;
    int results_seen;
    int closes_seen;
    int errors_seen;

    logic [7:0]  stream_bytes[$];
    int          length_spots[$];
    logic [31:0] rows_cfg     = '0;
    bit          calm         = 1'b0;
    int          gap_pct      = 0;
    int          bytes_sent   = 0;
    int          streams_sent = 0;
    int          quiet_cycles = 0;

    dictionary_sequence_parser_unit #(
        .MAX_DICTS   (MAX_DICTS),
        .DICT_BUDGET (DICT_BUDGET)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dict_parse_checker #(
        .MAX_DICTS   (MAX_DICTS),
        .DICT_BUDGET (DICT_BUDGET)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_valid      (s_axis_tvalid),
        .i_req_ready      (s_axis_tready),
        .i_req_byte       (s_axis_tdata),
        .i_req_last       (s_axis_tlast),
        .i_res_valid      (m_axis_tvalid),
        .i_res_ready      (m_axis_tready),
        .i_res_data       (m_axis_tdata),
        .i_res_kind       (m_axis_tuser),
        .i_res_end        (m_axis_tlast),
        .o_fail_count     (fail_count),
        .o_parses_pending (parses_pending),
        .o_results_seen   (results_seen),
        .o_closes_seen    (closes_seen),
        .o_errors_seen    (errors_seen)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: ready in random runs with stall bursts, steady once calm
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one byte request, optionally after a random gap
    task automatic push_byte(input logic [7:0] value, input logic last);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_stream();
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 30;
        endcase
        foreach (stream_bytes[k]) push_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        streams_sent++;
    endtask

    // wait until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (parses_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_rows(input logic [31:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rows_cfg     = value;
    endtask

    // add one byte at the end of the stream under construction
    function automatic void append_byte(input logic [7:0] value);
        stream_bytes = {stream_bytes, value};
    endfunction

    // entries that fit the budget, then the closing marker and its count
    function automatic void add_dictionary(input logic [7:0] marker, input logic [31:0] matched,
                                           input bit sparse);
        int used;
        int entries;
        int room;
        int len;
        int e;
        int k;
        bit crowded;
        used    = 0;
        crowded = !sparse && ($urandom_range(0, 7) == 0);
        if (sparse)
            entries = ($urandom_range(0, 7) == 0) ? 1 : 0;
        else if (crowded)
            entries = $urandom_range(32, DICT_BUDGET - 1);
        else
            entries = $urandom_range(0, 4);
        for (e = 0; e < entries && used < DICT_BUDGET - 1; e++) begin
            room = DICT_BUDGET - 2 - used;
            if (crowded)
                len = 0;
            else if (sparse)
                len = $urandom_range(0, 2);
            else if ($urandom_range(0, 5) == 0)
                len = room;
            else
                len = $urandom_range(0, (room < 12) ? room : 12);
            length_spots = {length_spots, int'(stream_bytes.size())};
            append_byte(8'(len));
            repeat (len) append_byte(8'($urandom));
            used += 1 + len;
        end
        append_byte(marker);
        for (k = 0; k < 4; k++) append_byte(matched[8*k +: 8]);
    endfunction

    // mostly well-formed sequences, some truncated, corrupted or pure noise
    function automatic void build_stream();
        int          dicts;
        int          d;
        int          cut;
        bit          ends_final;
        logic [63:0] total;
        logic [63:0] room;
        logic [31:0] matched;
        stream_bytes.delete();
        length_spots.delete();
        dicts      = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        ends_final = ($urandom_range(0, 9) != 0);
        total      = '0;
        for (d = 0; d < dicts; d++) begin
            if (d == dicts - 1 && ends_final) begin
                room    = (total <= 64'(rows_cfg)) ? 64'(rows_cfg) - total : 64'd0;
                matched = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, room[31:0]);
                add_dictionary(dsp_pkg::MARKER_LAST, matched, 1'b0);
                repeat ($urandom_range(0, 8)) append_byte(8'($urandom));
            end else begin
                case ($urandom_range(0, 7))
                    0:       matched = '0;
                    1:       matched = $urandom;
                    2:       matched = '1;
                    default: matched = $urandom_range(0, rows_cfg / 16);
                endcase
                add_dictionary(dsp_pkg::MARKER_NEXT, matched, 1'b0);
            end
            total += 64'(matched);
        end
        case ($urandom_range(0, 9))
            6: begin
                cut          = $urandom_range(1, stream_bytes.size());
                stream_bytes = stream_bytes[0:cut-1];
            end
            7: stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] = 8'($urandom);
            8: begin
                if (length_spots.size() != 0)
                    stream_bytes[length_spots[$urandom_range(0, length_spots.size() - 1)]] =
                        8'($urandom_range(dsp_pkg::MAX_ENTRY_LEN,
                                          dsp_pkg::MARKER_NEXT - 8'd1));
            end
            9: begin
                stream_bytes.delete();
                repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    // every dictionary slot used, the last one closed by the non-final marker
    function automatic void build_dictionary_run();
        int d;
        stream_bytes.delete();
        length_spots.delete();
        for (d = 0; d < MAX_DICTS; d++) add_dictionary(dsp_pkg::MARKER_NEXT, $urandom, 1'b1);
        repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
    endfunction

    // stimulus
    initial begin
        int          phase_idx;
        int          run_start;
        int          phase_end;
        logic [31:0] settings[4];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_rows('0);

        // directed corner streams
        stream_bytes = '{8'h00};                      // empty entry on the final byte
        send_stream();
        stream_bytes = '{8'h05};                      // entry cut off at its length byte
        send_stream();
        stream_bytes = '{dsp_pkg::MAX_ENTRY_LEN + 8'd1, 8'h00}; // length too long, discarded
        send_stream();
        stream_bytes = '{dsp_pkg::MAX_ENTRY_LEN, 8'h00};   // longest entry breaks the budget
        send_stream();
        stream_bytes = '{dsp_pkg::MARKER_LAST};            // stream ends on the marker
        send_stream();
        stream_bytes = '{dsp_pkg::MARKER_NEXT, 8'h01};     // stream ends inside the count
        send_stream();
        stream_bytes = '{dsp_pkg::MARKER_LAST, 8'h01, 8'h00, 8'h00, 8'h00}; // beyond rows
        send_stream();
        stream_bytes = '{8'h01, 8'hAB, dsp_pkg::MARKER_NEXT, 8'h00, 8'h00, 8'h00, 8'h00,
                         dsp_pkg::MARKER_LAST, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_stream();

        // dictionary limit, counted against MAX_DICTS
        build_dictionary_run();
        send_stream();
        run_start = bytes_sent;

        // random streams under several row limits share what is left
        settings = '{$urandom, '1, $urandom_range(0, 40), $urandom_range(1000, 100000)};
        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            write_rows(settings[phase_idx]);
            phase_end = run_start + (TOTAL_ITEMS - run_start) * (phase_idx + 1) / 4;
            do begin
                calm = (bytes_sent >= TOTAL_ITEMS - CALM_ITEMS);
                build_stream();
                send_stream();
            end while (bytes_sent < phase_end);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("streams %0d, bytes %0d, a full dictionary run, row limits tried %0d plus zero",
                 streams_sent, bytes_sent, 4);
        $display("results checked %0d: %0d dictionary closes, %0d error reports, %0d failures",
                 results_seen, closes_seen, errors_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dsp_pkg.sv
rtl/core/dsp_parse.sv
rtl/core/dictionary_sequence_parser_unit.sv
dv/dict_parse_checker.sv
dv/tb_dictionary_sequence_parser_unit.sv
